@@ rtl/ftws_pkg.sv @@
// shared types and constants for the frame time window statistics block
`default_nettype none
package ftws_pkg;

  localparam int DEF_WINDOW_DEPTH = 256;
  localparam int DEF_SAMPLE_BITS  = 24;
  localparam int FRAME_CNT_BITS   = 64;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clear_wr;    // write zero at the sweep address and advance it
    logic capture;     // input transfer: latch sample, advance slot, read the new slot's old value
    logic update;      // write sample, update sum and frame counter, start scan
    logic scan_step;   // read ring at the sweep address and advance it
    logic load_out;    // move results into the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic addr_last;   // sweep address is at the last ring entry
    logic out_busy;    // output register holds a result that is not taken this cycle
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/ftws_ctrl.sv @@
// controller state machine for the frame time window statistics block
`default_nettype none
module ftws_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ftws_pkg::stat_t stat,
  output ftws_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    UPDATE,
    SCAN,
    DRAIN,
    LOAD
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.addr_last) begin
          state_next = IDLE;
        end
      end
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = UPDATE;
        end
      end
      UPDATE: begin
        cmd.update = 1'b1;
        state_next = SCAN;
      end
      SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.addr_last) begin
          state_next = DRAIN;
        end
      end
      // last ring read is compared in this cycle
      DRAIN: begin
        state_next = LOAD;
      end
      LOAD: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        assert (state_next == UPDATE)
          else $error("input transfer did not start an update");
      end
    end
  end

  property p_accept_blocks;
    @(posedge clk) disable iff (rst)
      (in_valid && in_ready) |=> !in_ready;
  endproperty
  a_accept_blocks: assert property (p_accept_blocks)
    else $error("new transfer taken while an item is in work");

  property p_scan_follows_update;
    @(posedge clk) disable iff (rst)
      cmd.update |=> cmd.scan_step;
  endproperty
  a_scan_follows_update: assert property (p_scan_follows_update)
    else $error("window scan did not follow the update");

  property p_load_only_free;
    @(posedge clk) disable iff (rst)
      cmd.load_out |-> !stat.out_busy;
  endproperty
  a_load_only_free: assert property (p_load_only_free)
    else $error("result loaded over one not yet taken");

endmodule
`default_nettype wire

@@ rtl/ftws_datapath.sv @@
// ring memory, running sum, frame counter, max scan and output register
`default_nettype none
module ftws_datapath #(
  parameter int WINDOW_DEPTH = ftws_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = ftws_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ftws_pkg::cmd_t                    cmd,
  output ftws_pkg::stat_t                        stat,
  input  wire logic [SAMPLE_BITS-1:0]            frame_time,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [SAMPLE_BITS-1:0]                 latest_time,
  output logic [SAMPLE_BITS-1:0]                 average_time,
  output logic [SAMPLE_BITS-1:0]                 max_time,
  output logic [ftws_pkg::FRAME_CNT_BITS-1:0]    frame_total
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int SUM_W = SAMPLE_BITS + AW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

  logic [SAMPLE_BITS-1:0] ring [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          addr;
  logic [AW-1:0]          slot;
  logic [AW-1:0]          slot_inc;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SUM_W-1:0]       window_sum;
  logic [ftws_pkg::FRAME_CNT_BITS-1:0] frame_counter;
  logic [SAMPLE_BITS-1:0] peak;
  logic                   cmp_vld;

  assign slot_inc = slot + AW'(1);
  assign rd_addr  = cmd.capture ? slot_inc : addr;

  assign stat.addr_last = (addr == LAST_ADDR);
  assign stat.out_busy  = out_valid && !out_ready;

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      ring[addr] <= '0;
    end else if (cmd.update) begin
      ring[slot] <= sample;
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr          <= '0;
      slot          <= '0;
      window_sum    <= '0;
      frame_counter <= '0;
      cmp_vld       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_step;
      if (cmd.clear_wr || cmd.scan_step) begin
        addr <= stat.addr_last ? '0 : addr + AW'(1);
      end
      if (cmd.capture) begin
        slot <= slot_inc;
      end
      if (cmd.update) begin
        // rd_data holds the old value of the slot being overwritten
        window_sum    <= window_sum - SUM_W'(rd_data) + SUM_W'(sample);
        frame_counter <= frame_counter + ftws_pkg::FRAME_CNT_BITS'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= frame_time;
    end
    if (cmd.update) begin
      peak <= '0;
    end else if (cmp_vld && (rd_data > peak)) begin
      peak <= rd_data;
    end
    if (cmd.load_out) begin
      latest_time  <= sample;
      average_time <= window_sum[SUM_W-1 -: SAMPLE_BITS];
      max_time     <= peak;
      frame_total  <= frame_counter;
    end
  end

  property p_avg_below_max;
    @(posedge clk) disable iff (rst)
      out_valid |-> (average_time <= max_time);
  endproperty
  a_avg_below_max: assert property (p_avg_below_max)
    else $error("window average above window maximum");

  property p_latest_below_max;
    @(posedge clk) disable iff (rst)
      out_valid |-> (latest_time <= max_time);
  endproperty
  a_latest_below_max: assert property (p_latest_below_max)
    else $error("latest sample above window maximum");

  property p_scan_from_zero;
    @(posedge clk) disable iff (rst)
      cmd.update |=> (addr == '0);
  endproperty
  a_scan_from_zero: assert property (p_scan_from_zero)
    else $error("window scan does not start at the first entry");

endmodule
`default_nettype wire

@@ rtl/frame_time_window_stats_unit.sv @@
// Frame time window statistics: each transfer on the input channel carries one frame time in
// microseconds; the block stores it in a ring of WINDOW_DEPTH samples (the first sample after
// reset goes to slot 1), keeps a running sum and a 64-bit frame count, and returns one result
// with the latest sample, the sum shifted down by log2(WINDOW_DEPTH) (empty slots count as
// zero), the window maximum and the frame count. After reset a clearing pass writes zero to
// every ring entry, during which no input is taken. Each item then goes through the update,
// the maximum scan, which reads the ring one entry per cycle, a drain step and the load
// into the output register, and no new item is taken before that load. The result sits in
// an output register, and the next item is taken while it waits; WINDOW_DEPTH must be a
// power of two.
`default_nettype none
module frame_time_window_stats_unit #(
  parameter int WINDOW_DEPTH = ftws_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = ftws_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [SAMPLE_BITS-1:0]         frame_time,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [SAMPLE_BITS-1:0]              latest_time,
  output logic [SAMPLE_BITS-1:0]              average_time,
  output logic [SAMPLE_BITS-1:0]              max_time,
  output logic [ftws_pkg::FRAME_CNT_BITS-1:0] frame_total
);

  ftws_pkg::cmd_t  cmd;
  ftws_pkg::stat_t stat;

  ftws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ftws_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .frame_time   (frame_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .latest_time  (latest_time),
    .average_time (average_time),
    .max_time     (max_time),
    .frame_total  (frame_total)
  );

endmodule
`default_nettype wire

@@ test/tb.sv @@
// testbench for frame_time_window_stats_unit: directed frames, then random frame sequences
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = ftws_pkg::DEF_WINDOW_DEPTH;
  localparam int SBITS       = ftws_pkg::DEF_SAMPLE_BITS;
  localparam int CNT_BITS    = ftws_pkg::FRAME_CNT_BITS;
  localparam int DEPTH_LOG2  = $clog2(DEPTH);
  localparam int RANDOM_RUN  = 1140;
  localparam int CALM_RUN    = 100;
  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE      = DEPTH + 40;

  typedef struct packed {
    logic [SBITS-1:0]    latest;
    logic [SBITS-1:0]    avg;
    logic [SBITS-1:0]    peak;
    logic [CNT_BITS-1:0] total;
  } stats_t;

  typedef struct packed {
    logic [SBITS-1:0] ft;
    logic             typed;
    stats_t           want;
  } row_t;

  typedef enum int {SEG_ANY, SEG_LOW, SEG_HIGH, SEG_ONEHOT, SEG_RAMP} seg_kind_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [SBITS-1:0]          frame_time = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [SBITS-1:0]          latest_time;
  logic [SBITS-1:0]          average_time;
  logic [SBITS-1:0]          max_time;
  logic [CNT_BITS-1:0]       frame_total;

  // predictor state
  logic [SBITS-1:0]          ring_copy [DEPTH];
  logic [DEPTH_LOG2-1:0]     last_slot;
  logic [SBITS+DEPTH_LOG2-1:0] ring_sum;
  logic [CNT_BITS-1:0]       frames_seen;

  stats_t stats_due [$];
  stats_t head;
  row_t   directed_rows [12];

  int  err_count = 0;
  int  sent = 0;
  int  checked = 0;
  bit  idle_en = 1'b1;
  bit  hold_req = 1'b0;

  frame_time_window_stats_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .frame_time(frame_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .latest_time(latest_time), .average_time(average_time),
    .max_time(max_time), .frame_total(frame_total)
  );

  always #6 clk = ~clk;

  initial begin
    #30_000_000;
    $display("timeout: %0d frames sent, %0d results checked", sent, checked);
    $display("TB_ERROR");
    $finish;
  end

  function automatic stats_t store_frame(logic [SBITS-1:0] ft);
    stats_t r;
    int k;
    last_slot = last_slot + 1'b1;
    ring_sum = ring_sum - ring_copy[last_slot] + ft;
    ring_copy[last_slot] = ft;
    frames_seen = frames_seen + 1'b1;
    r.latest = ft;
    r.avg = SBITS'(ring_sum >> DEPTH_LOG2);
    r.peak = '0;
    for (k = 0; k < DEPTH; k++) begin
      if (ring_copy[k] > r.peak) r.peak = ring_copy[k];
    end
    r.total = frames_seen;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < 50)
      $display("mismatch on result %0d: %s got %0h expected %0h", checked, field, got, want);
    err_count++;
  endtask

  task automatic send_frame(input logic [SBITS-1:0] ft, input logic typed, input stats_t want);
    int gap;
    stats_t pred;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    frame_time <= ft;
    do @(posedge clk); while (!in_ready);
    pred = store_frame(ft);
    stats_due.push_back(typed ? want : pred);
    sent++;
  endtask

  // drop valid after the last transfer, then wait for every result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts, one long hold on request
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (stats_due.size() == 0) begin
        report_mismatch("unexpected result", 64'(latest_time), '0);
      end else begin
        head = stats_due.pop_front();
        if (latest_time !== head.latest)
          report_mismatch("latest_time", 64'(latest_time), 64'(head.latest));
        if (average_time !== head.avg)
          report_mismatch("average_time", 64'(average_time), 64'(head.avg));
        if (max_time !== head.peak)
          report_mismatch("max_time", 64'(max_time), 64'(head.peak));
        if (frame_total !== head.total)
          report_mismatch("frame_total", 64'(frame_total), 64'(head.total));
      end
      checked++;
    end
  end

  initial begin
    int i;
    int n;
    int seg_len;
    int waited;
    seg_kind_t seg;
    logic [SBITS-1:0] v;
    logic [SBITS-1:0] ramp_step;

    for (i = 0; i < DEPTH; i++) ring_copy[i] = '0;
    last_slot = '0;
    ring_sum = '0;
    frames_seen = '0;

    // first frames after reset can be worked out by hand
    directed_rows[0]  = '{24'hFFFFFF, 1'b1, '{24'hFFFFFF, 24'h00FFFF, 24'hFFFFFF, 64'd1}};
    directed_rows[1]  = '{24'h000000, 1'b1, '{24'h000000, 24'h00FFFF, 24'hFFFFFF, 64'd2}};
    directed_rows[2]  = '{24'h000001, 1'b1, '{24'h000001, 24'h010000, 24'hFFFFFF, 64'd3}};
    directed_rows[3]  = '{24'h800000, 1'b0, '0};
    directed_rows[4]  = '{24'h7FFFFF, 1'b0, '0};
    directed_rows[5]  = '{24'h555555, 1'b0, '0};
    directed_rows[6]  = '{24'hAAAAAA, 1'b0, '0};
    directed_rows[7]  = '{24'h000100, 1'b0, '0};
    directed_rows[8]  = '{24'h0000FF, 1'b0, '0};
    directed_rows[9]  = '{24'hFFFFFE, 1'b0, '0};
    directed_rows[10] = '{24'h000000, 1'b0, '0};
    directed_rows[11] = '{24'h123456, 1'b0, '0};

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < 12; i++)
      send_frame(directed_rows[i].ft, directed_rows[i].typed, directed_rows[i].want);

    // long output hold while frames keep coming, so the input backs up
    hold_req = 1'b1;
    for (i = 0; i < 10; i++) send_frame(SBITS'($urandom()), 1'b0, '0);
    wait_drained();

    // full scale window drives the sum to its top, then zeros bring the max back to zero
    for (i = 0; i < DEPTH + 4; i++) send_frame(24'hFFFFFF, 1'b0, '0);
    for (i = 0; i < DEPTH + 4; i++) send_frame(24'h000000, 1'b0, '0);

    n = 0;
    while (n < RANDOM_RUN - 2 * (DEPTH + 4) - 10) begin
      seg = seg_kind_t'($urandom_range(0, 4));
      seg_len = $urandom_range(20, 120);
      v = SBITS'($urandom());
      ramp_step = SBITS'($urandom_range(0, 65535));
      if ($urandom_range(0, 5) == 0) wait_drained();
      for (i = 0; i < seg_len; i++) begin
        case (seg)
          SEG_ANY:    v = SBITS'($urandom());
          SEG_LOW:    v = SBITS'($urandom_range(0, 255));
          SEG_HIGH:   v = 24'hFFFFFF - SBITS'($urandom_range(0, 255));
          SEG_ONEHOT: v = 24'h1 << $urandom_range(0, 23);
          SEG_RAMP:   v = v + ramp_step;
          default:    v = '0;
        endcase
        send_frame(v, 1'b0, '0);
      end
      n += seg_len;
    end

    // closing stretch runs flat out on both sides
    idle_en = 1'b0;
    for (i = 0; i < CALM_RUN; i++) send_frame(SBITS'($urandom()), 1'b0, '0);
    @(negedge clk);
    in_valid <= 1'b0;

    waited = 0;
    while (stats_due.size() != 0 && waited < 20 * SETTLE) begin
      @(posedge clk);
      waited++;
    end
    if (stats_due.size() != 0)
      report_mismatch("results never returned", 64'(stats_due.size()), '0);
    repeat (SETTLE) @(posedge clk);

    $display("%0d frames through a %0d-deep window (pointer wrapped %0d times), %0d results",
             sent, DEPTH, sent / DEPTH, checked);
    $display("covered full-scale and all-zero windows, long output hold, %0d mismatches",
             err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ftws_pkg.sv
rtl/ftws_ctrl.sv
rtl/ftws_datapath.sv
rtl/frame_time_window_stats_unit.sv
test/tb.sv
